// File: rtl/core/ncpc_pkg.sv
// ncpc_pkg: shared constants, types and helpers of the nearest center pixel classifier
// no dependencies; used by every module of the block
`default_nettype none

package ncpc_pkg;

    // block sizing
    localparam int MAX_CLASSES = 8;
    localparam int COUNT_BITS  = 24;
    localparam int CLS_W       = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

    // field widths
    localparam int PIX_W       = 8;
    localparam int SQPIX_W     = 2 * PIX_W;
    localparam int CTR_W       = 16;
    localparam int ID_W        = 3;
    localparam int OUT_COUNT_W = 24;
    localparam int SUM_W       = 32;
    localparam int SQ_W        = 40;
    localparam int ACT_W       = 4;
    localparam int CNT_CMP_W   = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;

    // register port
    localparam int NUM_PAIRS   = 4;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_CLASSES = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_CENTERS_PAIR_0 = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_CENTERS_PAIR_1 = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_CENTERS_PAIR_2 = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_CENTERS_PAIR_3 = REG_IDX_W'(4);

    localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(8);

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        ACT_CLASSIFY = 2'd0,
        ACT_READ     = 2'd1,
        ACT_CLEAR    = 2'd2,
        ACT_NOP      = 2'd3
    } t_action;

    typedef struct packed {
        t_action           action;
        logic [PIX_W-1:0]  pixel_value;
        logic [ID_W-1:0]   class_select;
    } t_in_word;

    typedef struct packed {
        logic [ID_W-1:0]        class_id;
        logic [OUT_COUNT_W-1:0] member_count;
        logic [SUM_W-1:0]       value_sum;
        logic [SQ_W-1:0]        square_sum;
    } t_out_word;

    // classified operation handed from front to back
    typedef struct packed {
        t_action            action;
        logic [ID_W-1:0]    class_id;
        logic [PIX_W-1:0]   pixel;
        logic [SQPIX_W-1:0] pixel_sq;
    } t_op;

    typedef logic [MAX_CLASSES-1:0][CTR_W-1:0] t_centers;

    // stored count as shown on the output field, saturating
    function automatic logic [OUT_COUNT_W-1:0] clamp_count(input logic [COUNT_BITS-1:0] cnt);
        logic [CNT_CMP_W-1:0] wide;
        logic [CNT_CMP_W-1:0] lim;
        wide = CNT_CMP_W'(cnt);
        lim  = CNT_CMP_W'({OUT_COUNT_W{1'b1}});
        if (wide > lim) begin
            return {OUT_COUNT_W{1'b1}};
        end
        return wide[OUT_COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ncpc_front.sv
// ncpc_front: accepts input words, finds the nearest center and squares the pixel
// depends on ncpc_pkg
`default_nettype none

module ncpc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire ncpc_pkg::t_in_word i_in_data,
    input  wire logic [ncpc_pkg::ACT_W-1:0] i_active,
    input  wire ncpc_pkg::t_centers i_centers,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output ncpc_pkg::t_op          o_op
);

    logic                 r_valid;
    logic                 n_valid;
    ncpc_pkg::t_op        r_op;
    ncpc_pkg::t_op        n_op;
    logic                 accept;
    logic [ncpc_pkg::CLS_W-1:0] best;

    assign o_in_stall = r_valid && i_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_valid    = r_valid;
    assign o_op       = r_op;

    // distances compared as absolute differences, same order as squares
    always_comb begin
        logic [ncpc_pkg::CTR_W-1:0] p88;
        logic [ncpc_pkg::CTR_W-1:0] c_diff [ncpc_pkg::MAX_CLASSES];
        logic [ncpc_pkg::CTR_W-1:0] best_d;
        p88 = {i_in_data.pixel_value, 8'h00};
        for (int k = 0; k < ncpc_pkg::MAX_CLASSES; k++) begin
            c_diff[k] = (p88 >= i_centers[k]) ? (p88 - i_centers[k]) : (i_centers[k] - p88);
        end
        best   = '0;
        best_d = c_diff[0];
        for (int k = 1; k < ncpc_pkg::MAX_CLASSES; k++) begin
            if ((ncpc_pkg::ACT_W'(k) < i_active) && (c_diff[k] < best_d)) begin
                best   = ncpc_pkg::CLS_W'(k);
                best_d = c_diff[k];
            end
        end
    end

    always_comb begin
        n_op          = r_op;
        n_valid       = r_valid && i_stall;
        if (accept) begin
            n_valid       = 1'b1;
            n_op.action   = i_in_data.action;
            n_op.pixel    = i_in_data.pixel_value;
            n_op.pixel_sq = ncpc_pkg::SQPIX_W'(i_in_data.pixel_value) *
                            ncpc_pkg::SQPIX_W'(i_in_data.pixel_value);
            if (i_in_data.action == ncpc_pkg::ACT_CLASSIFY) begin
                n_op.class_id = ncpc_pkg::ID_W'(best);
            end else begin
                n_op.class_id = i_in_data.class_select;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_op <= n_op;
    end

endmodule

`default_nettype wire

// File: rtl/core/ncpc_queue.sv
// ncpc_queue: short fifo of classified operations between front and back
// depends on ncpc_pkg
`default_nettype none

module ncpc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ncpc_pkg::t_op i_op,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output ncpc_pkg::t_op      o_op
);

    ncpc_pkg::t_op               r_mem [ncpc_pkg::QDEPTH];
    logic [ncpc_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [ncpc_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [ncpc_pkg::QCNT_W-1:0] r_cnt;
    logic [ncpc_pkg::QPTR_W-1:0] n_wr_ptr;
    logic [ncpc_pkg::QPTR_W-1:0] n_rd_ptr;
    logic [ncpc_pkg::QCNT_W-1:0] n_cnt;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_cnt == ncpc_pkg::QCNT_W'(ncpc_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == ncpc_pkg::QPTR_W'(ncpc_pkg::QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == ncpc_pkg::QPTR_W'(ncpc_pkg::QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ncpc_back.sv
// ncpc_back: per-class saturating accumulators and the output register
// depends on ncpc_pkg
`default_nettype none

module ncpc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_pop,
    input  wire ncpc_pkg::t_op i_op,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ncpc_pkg::t_out_word o_out_data
);

    logic [ncpc_pkg::COUNT_BITS-1:0] r_count [ncpc_pkg::MAX_CLASSES];
    logic [ncpc_pkg::SUM_W-1:0]      r_sum   [ncpc_pkg::MAX_CLASSES];
    logic [ncpc_pkg::SQ_W-1:0]       r_sq    [ncpc_pkg::MAX_CLASSES];
    logic [ncpc_pkg::COUNT_BITS-1:0] n_count [ncpc_pkg::MAX_CLASSES];
    logic [ncpc_pkg::SUM_W-1:0]      n_sum   [ncpc_pkg::MAX_CLASSES];
    logic [ncpc_pkg::SQ_W-1:0]       n_sq    [ncpc_pkg::MAX_CLASSES];
    logic                            r_out_valid;
    logic                            n_out_valid;
    ncpc_pkg::t_out_word             r_out;
    ncpc_pkg::t_out_word             n_out;
    logic [ncpc_pkg::CLS_W-1:0]      idx;
    logic [ncpc_pkg::COUNT_BITS-1:0] cur_count;
    logic [ncpc_pkg::SUM_W-1:0]      cur_sum;
    logic [ncpc_pkg::SQ_W-1:0]       cur_sq;
    logic [ncpc_pkg::COUNT_BITS-1:0] add_count;
    logic [ncpc_pkg::SUM_W:0]        add_sum;
    logic [ncpc_pkg::SQ_W:0]         add_sq;
    logic [ncpc_pkg::COUNT_BITS-1:0] new_count;
    logic [ncpc_pkg::SUM_W-1:0]      new_sum;
    logic [ncpc_pkg::SQ_W-1:0]       new_sq;
    logic                            in_range;

    assign o_pop       = i_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign idx       = i_op.class_id[ncpc_pkg::CLS_W-1:0];
    assign in_range  = (4'(i_op.class_id) < 4'(ncpc_pkg::MAX_CLASSES));
    assign cur_count = r_count[idx];
    assign cur_sum   = r_sum[idx];
    assign cur_sq    = r_sq[idx];

    // saturating updates
    assign add_count = cur_count + 1'b1;
    assign add_sum   = {1'b0, cur_sum} + (ncpc_pkg::SUM_W + 1)'(i_op.pixel);
    assign add_sq    = {1'b0, cur_sq} + (ncpc_pkg::SQ_W + 1)'(i_op.pixel_sq);
    assign new_count = (&cur_count) ? cur_count : add_count;
    assign new_sum   = add_sum[ncpc_pkg::SUM_W] ? {ncpc_pkg::SUM_W{1'b1}}
                                                : add_sum[ncpc_pkg::SUM_W-1:0];
    assign new_sq    = add_sq[ncpc_pkg::SQ_W] ? {ncpc_pkg::SQ_W{1'b1}}
                                              : add_sq[ncpc_pkg::SQ_W-1:0];

    always_comb begin
        n_count     = r_count;
        n_sum       = r_sum;
        n_sq        = r_sq;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (o_pop) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            unique case (i_op.action)
                ncpc_pkg::ACT_CLASSIFY: begin
                    n_count[idx]       = new_count;
                    n_sum[idx]         = new_sum;
                    n_sq[idx]          = new_sq;
                    n_out.class_id     = i_op.class_id;
                    n_out.member_count = ncpc_pkg::clamp_count(new_count);
                    n_out.value_sum    = new_sum;
                    n_out.square_sum   = new_sq;
                end
                ncpc_pkg::ACT_READ: begin
                    n_out.class_id = i_op.class_id;
                    if (in_range) begin
                        n_out.member_count = ncpc_pkg::clamp_count(cur_count);
                        n_out.value_sum    = cur_sum;
                        n_out.square_sum   = cur_sq;
                    end
                end
                ncpc_pkg::ACT_CLEAR: begin
                    for (int k = 0; k < ncpc_pkg::MAX_CLASSES; k++) begin
                        n_count[k] = '0;
                        n_sum[k]   = '0;
                        n_sq[k]    = '0;
                    end
                end
                ncpc_pkg::ACT_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int k = 0; k < ncpc_pkg::MAX_CLASSES; k++) begin
                r_count[k] <= '0;
                r_sum[k]   <= '0;
                r_sq[k]    <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_sq        <= n_sq;
        end
        r_out <= n_out;
    end

endmodule

`default_nettype wire

// File: rtl/core/nearest_center_pixel_classifier_top.sv
// nearest_center_pixel_classifier_top: register port, front, queue and back
// depends on ncpc_pkg, ncpc_front, ncpc_queue, ncpc_back
//
// usage
//   input channel i_in_valid / o_in_stall carries one word per item: action
//   classify (pixel to nearest active center, accumulators updated), read
//   (one class's count, sum and square sum), clear (all accumulators zero) or nop
//   output channel o_out_valid / i_out_stall returns exactly one word per item
//   throughput: one word per cycle while the receiver does not stall; the accumulator
//   read-modify-write in the back stage is combinational, so same-class runs do not stall
//   path to o_out_valid: front register, then queue entry, then output register
//   receiver stall: the output register holds, the 2-entry queue fills, then the
//   front register holds and o_in_stall rises; nothing is dropped
//   reset: accumulators zero, active_classes 8, all centers 0; no clearing pass,
//   the block takes words right after reset
//   apb: active_classes at 0x00, center pairs at 0x04..0x10; write only while idle
`default_nettype none

module nearest_center_pixel_classifier_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire ncpc_pkg::t_in_word            i_in_data,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output ncpc_pkg::t_out_word                o_out_data,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ncpc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [ncpc_pkg::PDATA_W-1:0]  pwdata,
    output logic [ncpc_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    logic [ncpc_pkg::ACT_W-1:0]   r_active;
    logic [ncpc_pkg::PDATA_W-1:0] r_pair [ncpc_pkg::NUM_PAIRS];
    logic [ncpc_pkg::REG_IDX_W-1:0] reg_idx;
    logic                         reg_wr;
    ncpc_pkg::t_centers           centers;

    logic          front_valid;
    ncpc_pkg::t_op front_op;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    ncpc_pkg::t_op q_op;

    // register port, zero wait states
    assign pready  = 1'b1;
    assign reg_idx = paddr[ncpc_pkg::PADDR_W-1:2];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ncpc_pkg::ACTIVE_RESET;
            for (int k = 0; k < ncpc_pkg::NUM_PAIRS; k++) begin
                r_pair[k] <= '0;
            end
        end else if (reg_wr) begin
            unique case (reg_idx)
                ncpc_pkg::REG_ACTIVE_CLASSES: r_active  <= pwdata[ncpc_pkg::ACT_W-1:0];
                ncpc_pkg::REG_CENTERS_PAIR_0: r_pair[0] <= pwdata;
                ncpc_pkg::REG_CENTERS_PAIR_1: r_pair[1] <= pwdata;
                ncpc_pkg::REG_CENTERS_PAIR_2: r_pair[2] <= pwdata;
                ncpc_pkg::REG_CENTERS_PAIR_3: r_pair[3] <= pwdata;
                default: begin
                    // unmapped addresses ignore writes
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ncpc_pkg::REG_ACTIVE_CLASSES: prdata = ncpc_pkg::PDATA_W'(r_active);
            ncpc_pkg::REG_CENTERS_PAIR_0: prdata = r_pair[0];
            ncpc_pkg::REG_CENTERS_PAIR_1: prdata = r_pair[1];
            ncpc_pkg::REG_CENTERS_PAIR_2: prdata = r_pair[2];
            ncpc_pkg::REG_CENTERS_PAIR_3: prdata = r_pair[3];
            default:                      prdata = '0;
        endcase
    end

    // unpack centers, two per pair register, low half is the even class
    always_comb begin
        for (int k = 0; k < ncpc_pkg::MAX_CLASSES; k++) begin
            centers[k] = r_pair[k / 2][(k % 2) * ncpc_pkg::CTR_W +: ncpc_pkg::CTR_W];
        end
    end

    // front: accept and classify
    ncpc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_active   (r_active),
        .i_centers  (centers),
        .o_valid    (front_valid),
        .i_stall    (q_full),
        .o_op       (front_op)
    );

    // decoupling queue
    ncpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_op    (front_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_op    (q_op)
    );

    // back: accumulate and deliver
    ncpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_pop       (q_pop),
        .i_op        (q_op),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// File: rtl/core/ncpc_checker.sv
// ncpc_checker: port-level checks of the classifier top, attached by bind
// depends on ncpc_pkg and nearest_center_pixel_classifier_top
`default_nettype none

module ncpc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire ncpc_pkg::t_out_word o_out_data,
    input wire logic               pready
);

    // words in flight: front register, queue, output register
    localparam int MAX_INFLIGHT = ncpc_pkg::QDEPTH + 2;

    logic [2:0] r_inflight;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (in_acc && !out_acc) begin
            r_inflight <= r_inflight + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_inflight <= r_inflight - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output word changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_inflight != '0)
        else $error("output word without an accepted input word");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'(MAX_INFLIGHT))
        else $error("more words in flight than storage holds");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind nearest_center_pixel_classifier_top ncpc_checker u_ncpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .pready      (pready)
);

`default_nettype wire

// File: dv/nearest_center_pixel_classifier_top_tb.sv
`timescale 1ns / 1ps
// nearest_center_pixel_classifier_top_tb: self-checking bench for the pixel classifier
// drives pixel, readout, clear and nop words under random idling and register settings
// depends on ncpc_pkg and nearest_center_pixel_classifier_top

module nearest_center_pixel_classifier_top_tb;

    import ncpc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // input channel
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_data = '0;
    // output channel
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_data;
    // register port
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    nearest_center_pixel_classifier_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // shadow of the register file and the class accumulators
    logic [ACT_W-1:0]       active_cfg;
    logic [PDATA_W-1:0]     center_pairs [NUM_PAIRS];
    logic [COUNT_BITS-1:0]  count_acc [MAX_CLASSES];
    logic [SUM_W-1:0]       sum_acc [MAX_CLASSES];
    logic [SQ_W-1:0]        sq_acc [MAX_CLASSES];

    t_in_word  words_to_send [$];
    t_out_word awaited_reports [$];

    bit in_busy;        // a word is on the input bus and not yet taken
    bit in_quiet;       // sender offers back to back
    bit out_quiet;      // receiver never stalls on its own
    bit hold_req;
    int hold_left;
    int in_gap;
    int stall_left;
    int mismatches;

    function automatic logic [CTR_W-1:0] center_val(input int k);
        logic [PDATA_W-1:0] pair;
        pair = center_pairs[k / 2];
        return (k % 2) ? pair[31:16] : pair[15:0];
    endfunction

    // accumulators of one class as shown on the output word
    function automatic t_out_word class_report(input logic [ID_W-1:0] id, input int idx);
        t_out_word r;
        r = '0;
        r.class_id = id;
        if (COUNT_BITS > OUT_COUNT_W && count_acc[idx] > {OUT_COUNT_W{1'b1}})
            r.member_count = '1;
        else
            r.member_count = OUT_COUNT_W'(count_acc[idx]);
        r.value_sum  = sum_acc[idx];
        r.square_sum = sq_acc[idx];
        return r;
    endfunction

    // nearest-center search plus saturating accumulator update
    function automatic t_out_word assign_and_accumulate(input t_in_word w);
        t_out_word  r;
        int         n;
        int         best;
        logic [31:0] best_d;
        logic [31:0] d2;
        logic [15:0] p88;
        logic [15:0] c;
        logic [15:0] diff;
        logic [15:0] psq;
        logic [32:0] s33;
        logic [40:0] s41;
        r = '0;
        case (w.action)
            ACT_CLASSIFY: begin
                n = int'(active_cfg);
                if (n < 1) n = 1;
                if (n > MAX_CLASSES) n = MAX_CLASSES;
                best = 0;
                best_d = '0;
                p88 = {w.pixel_value, 8'h00};
                for (int k = 0; k < n; k++) begin
                    c = center_val(k);
                    diff = (p88 >= c) ? p88 - c : c - p88;
                    d2 = diff * diff;
                    // strict compare keeps the lowest index on a tie
                    if (k == 0 || d2 < best_d) begin
                        best_d = d2;
                        best = k;
                    end
                end
                if (count_acc[best] != '1) count_acc[best] = count_acc[best] + 1'b1;
                s33 = {1'b0, sum_acc[best]} + w.pixel_value;
                sum_acc[best] = s33[32] ? '1 : s33[31:0];
                psq = w.pixel_value * w.pixel_value;
                s41 = {1'b0, sq_acc[best]} + psq;
                sq_acc[best] = s41[40] ? '1 : s41[39:0];
                r = class_report(ID_W'(best), best);
            end
            ACT_READ: begin
                if (int'(w.class_select) < MAX_CLASSES)
                    r = class_report(w.class_select, int'(w.class_select));
                else
                    r.class_id = w.class_select;
            end
            ACT_CLEAR: begin
                for (int k = 0; k < MAX_CLASSES; k++) begin
                    count_acc[k] = '0;
                    sum_acc[k] = '0;
                    sq_acc[k] = '0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatches < 100)
            $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // mostly short gaps, a few long ones
    function automatic int idle_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sender: a word stays on the bus until taken, then an optional gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!in_busy) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (words_to_send.size() > 0) begin
                i_in_data <= words_to_send.pop_front();
                i_in_valid <= 1'b1;
                in_busy = 1'b1;
                in_gap = idle_len(in_quiet);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // input side: predict each word that the block takes
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            awaited_reports.insert(awaited_reports.size(), assign_and_accumulate(i_in_data));
            in_busy = 1'b0;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = 300;
            hold_req = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            stall_left = idle_len(out_quiet);
            i_out_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // output side: compare with the oldest awaited report
    always @(posedge i_clk) begin : out_check
        t_out_word want;
        t_out_word got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_data;
            if (awaited_reports.size() == 0) begin
                flag_mismatch("unexpected word", 64'(got.square_sum), 64'd0);
            end else begin
                want = awaited_reports.pop_front();
                if (got.class_id !== want.class_id)
                    flag_mismatch("class_id", 64'(got.class_id), 64'(want.class_id));
                if (got.member_count !== want.member_count)
                    flag_mismatch("member_count", 64'(got.member_count),
                                  64'(want.member_count));
                if (got.value_sum !== want.value_sum)
                    flag_mismatch("value_sum", 64'(got.value_sum), 64'(want.value_sum));
                if (got.square_sum !== want.square_sum)
                    flag_mismatch("square_sum", 64'(got.square_sum), 64'(want.square_sum));
            end
        end
    end

    // register write, then read back and check
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] mask;
        mask = (idx == REG_ACTIVE_CLASSES) ? PDATA_W'({ACT_W{1'b1}}) : '1;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_ACTIVE_CLASSES)
            active_cfg = value[ACT_W-1:0];
        else
            center_pairs[int'(idx) - 1] = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) !== (value & mask))
            flag_mismatch("register readback", 64'(prdata & mask), 64'(value & mask));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_centers(input logic [CTR_W-1:0] cv [MAX_CLASSES]);
        write_reg(REG_CENTERS_PAIR_0, {cv[1], cv[0]});
        write_reg(REG_CENTERS_PAIR_1, {cv[3], cv[2]});
        write_reg(REG_CENTERS_PAIR_2, {cv[5], cv[4]});
        write_reg(REG_CENTERS_PAIR_3, {cv[7], cv[6]});
    endtask

    task automatic push_word(input t_action a, input logic [PIX_W-1:0] pix,
                             input logic [ID_W-1:0] sel);
        t_in_word w;
        w.action = a;
        w.pixel_value = pix;
        w.class_select = sel;
        words_to_send.insert(words_to_send.size(), w);
    endtask

    task automatic queue_random_words(input int count);
        int r;
        t_action a;
        logic [PIX_W-1:0] pix;
        logic [CTR_W-1:0] cv;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 72) a = ACT_CLASSIFY;
            else if (r < 90) a = ACT_READ;
            else if (r < 93) a = ACT_CLEAR;
            else a = ACT_NOP;
            pix = PIX_W'($urandom_range(0, 255));
            // land on or next to a center now and then
            if ($urandom_range(0, 3) == 0) begin
                cv = center_val($urandom_range(0, MAX_CLASSES - 1));
                pix = cv[15:8] + PIX_W'($urandom_range(0, 1));
            end
            push_word(a, pix, ID_W'($urandom_range(0, 7)));
        end
    endtask

    task automatic wait_drained();
        while (words_to_send.size() != 0 || in_busy || awaited_reports.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [CTR_W-1:0] cv [MAX_CLASSES];
        int r;
        active_cfg = ACTIVE_RESET;
        for (int k = 0; k < NUM_PAIRS; k++) center_pairs[k] = '0;
        for (int k = 0; k < MAX_CLASSES; k++) begin
            count_acc[k] = '0;
            sum_acc[k] = '0;
            sq_acc[k] = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: all centers at zero, every pixel ties into class 0
        push_word(ACT_CLASSIFY, 8'h00, 3'd5);
        push_word(ACT_CLASSIFY, 8'hFF, 3'd2);
        push_word(ACT_READ, 8'hA5, 3'd0);
        push_word(ACT_READ, 8'h5A, 3'd7);
        push_word(ACT_NOP, 8'hFF, 3'd7);
        push_word(ACT_CLEAR, 8'h00, 3'd0);
        push_word(ACT_READ, 8'h00, 3'd0);
        wait_drained();

        // spread centers with a duplicate and exact ties
        cv = '{16'h0000, 16'h2000, 16'h4000, 16'h4000,
               16'h8080, 16'hC000, 16'hFF00, 16'hFFFF};
        write_reg(REG_ACTIVE_CLASSES, 32'd8);
        write_centers(cv);
        push_word(ACT_CLASSIFY, 8'h10, 3'd0);   // tie between centers 0 and 1
        push_word(ACT_CLASSIFY, 8'h40, 3'd0);   // duplicate center, lower index
        push_word(ACT_CLASSIFY, 8'h80, 3'd0);   // fractional center
        push_word(ACT_CLASSIFY, 8'hFF, 3'd0);
        push_word(ACT_CLASSIFY, 8'h30, 3'd0);   // tie between centers 1 and 2
        push_word(ACT_CLASSIFY, 8'hE0, 3'd0);
        for (int k = 0; k < MAX_CLASSES; k++) push_word(ACT_READ, 8'h00, ID_W'(k));
        push_word(ACT_CLEAR, 8'hFF, 3'd7);
        push_word(ACT_READ, 8'h00, 3'd2);
        wait_drained();

        // zero active classes acts as one
        write_reg(REG_ACTIVE_CLASSES, 32'd0);
        push_word(ACT_CLASSIFY, 8'hFF, 3'd0);
        push_word(ACT_READ, 8'h00, 3'd0);
        wait_drained();

        // active classes above the maximum act as the maximum
        cv = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000};
        write_reg(REG_ACTIVE_CLASSES, 32'd15);
        write_centers(cv);
        push_word(ACT_CLASSIFY, 8'h00, 3'd0);
        push_word(ACT_CLASSIFY, 8'hFF, 3'd0);
        push_word(ACT_READ, 8'h00, 3'd7);
        wait_drained();

        // random settings, one phase with a long receiver hold-off
        for (int ph = 0; ph < 8; ph++) begin
            for (int k = 0; k < MAX_CLASSES; k++) begin
                r = $urandom_range(0, 9);
                if (r < 4) cv[k] = {8'($urandom_range(0, 255)), 8'h00};
                else if (r < 7) cv[k] = 16'($urandom);
                else if (r == 7 && k > 0) cv[k] = cv[k - 1];
                else cv[k] = r[0] ? 16'hFFFF : 16'h0000;
            end
            if (ph == 0) r = 1;
            else if (ph == 1) r = MAX_CLASSES;
            else if ($urandom_range(0, 99) < 15) r = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
            else r = $urandom_range(1, MAX_CLASSES);
            write_reg(REG_ACTIVE_CLASSES, PDATA_W'(r));
            write_centers(cv);
            in_quiet = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            if (ph == 3) begin
                // sender keeps offering while the receiver holds off
                in_quiet = 1'b1;
                out_quiet = 1'b0;
                hold_req = 1'b1;
            end
            queue_random_words(165);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && awaited_reports.size() == 0) begin
            $display("PASS nearest_center_pixel_classifier_top");
        end else begin
            $display("FAIL nearest_center_pixel_classifier_top");
        end
        $finish;
    end

    // run limit
    initial begin
        #6000000;
        $display("FAIL nearest_center_pixel_classifier_top");
        $finish;
    end

endmodule
